// ----- rtl/hsv8_pkg.sv -----
// Shared types and constants for the 8-bit RGB to HSV converter.
// Used by hsv8_front, hsv8_cell and rgb_to_hsv_8bit.
package hsv8_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 2 * ChanW;
  localparam int unsigned QuoW   = ChanW;
  localparam int unsigned NCells = QuoW;

  localparam logic [ChanW-1:0] HueStep     = 8'd43;
  localparam logic [ChanW-1:0] HueOfsRed   = 8'd0;
  localparam logic [ChanW-1:0] HueOfsGreen = 8'd85;
  localparam logic [ChanW-1:0] HueOfsBlue  = 8'd171;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] dsh;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [ChanW-1:0] bright;
    logic [ChanW-1:0] offset;
    logic             neg;
    logic             grey;
  } side_t;

  typedef struct packed {
    lane_t sat;
    lane_t hue;
    side_t side;
  } cell_t;

endpackage

// ----- rtl/hsv8_front.sv -----
// Front stage: channel max/min, hue sector, scaled numerators.
// Depends on hsv8_pkg.
module hsv8_front import hsv8_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             valid_r,
  output cell_t            data_r
);

  logic [ChanW-1:0] mx, mn, span, ha, hb, mag, ofs;
  logic [NumW-1:0]  sat_num, hue_num;
  cell_t            data_nxt;

  always_comb begin
    if (red >= green && red >= blue) begin
      mx  = red;
      ha  = green;
      hb  = blue;
      ofs = HueOfsRed;
    end else if (green >= blue) begin
      mx  = green;
      ha  = blue;
      hb  = red;
      ofs = HueOfsGreen;
    end else begin
      mx  = blue;
      ha  = red;
      hb  = green;
      ofs = HueOfsBlue;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    span = mx - mn;
    mag  = (ha >= hb) ? (ha - hb) : (hb - ha);
    sat_num = {span, {ChanW{1'b0}}} - {{ChanW{1'b0}}, span};
    hue_num = {{ChanW{1'b0}}, HueStep} * {{ChanW{1'b0}}, mag};

    data_nxt.sat.rem     = sat_num;
    data_nxt.sat.dsh     = {1'b0, mx, {(ChanW-1){1'b0}}};
    data_nxt.sat.quo     = '0;
    data_nxt.hue.rem     = hue_num;
    data_nxt.hue.dsh     = {1'b0, span, {(ChanW-1){1'b0}}};
    data_nxt.hue.quo     = '0;
    data_nxt.side.bright = mx;
    data_nxt.side.offset = ofs;
    data_nxt.side.neg    = (ha < hb);
    data_nxt.side.grey   = (span == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/hsv8_cell.sv -----
// One restoring-division cell: one quotient bit for both lanes per stage.
// Depends on hsv8_pkg.
module hsv8_cell import hsv8_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  cell_t in_data,
  output logic  valid_r,
  output cell_t data_r
);

  cell_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    if (in_data.sat.rem >= in_data.sat.dsh) begin
      data_nxt.sat.rem = in_data.sat.rem - in_data.sat.dsh;
      data_nxt.sat.quo = {in_data.sat.quo[QuoW-2:0], 1'b1};
    end else begin
      data_nxt.sat.quo = {in_data.sat.quo[QuoW-2:0], 1'b0};
    end
    data_nxt.sat.dsh = {1'b0, in_data.sat.dsh[NumW-1:1]};
    if (in_data.hue.rem >= in_data.hue.dsh) begin
      data_nxt.hue.rem = in_data.hue.rem - in_data.hue.dsh;
      data_nxt.hue.quo = {in_data.hue.quo[QuoW-2:0], 1'b1};
    end else begin
      data_nxt.hue.quo = {in_data.hue.quo[QuoW-2:0], 1'b0};
    end
    data_nxt.hue.dsh = {1'b0, in_data.hue.dsh[NumW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/rgb_to_hsv_8bit.sv -----
// Top level of the 8-bit RGB to HSV converter.
// Depends on hsv8_pkg, hsv8_front and hsv8_cell.
//
// Input channel in_*: one pixel per item, in_tdata = {blue, green, red}.
// Output channel out_*: one HSV item per pixel, out_tdata =
// {brightness, saturation, hue}, in input order.
// Stages from accept to out_tvalid: front stage, eight division cells,
// output register. Throughput: one item per cycle while the receiver does not stall.
// Each division cell resolves one quotient bit of both the saturation and
// the hue divide, so the quotient width sets the cell count.
// Every stage has its own valid bit; a stage loads when it is empty or its
// successor loads, so bubbles close up while the receiver stalls and
// in_tready stays high until all stages hold items.
// Reset clears all valid bits; no item is lost or repeated across stalls.
module rgb_to_hsv_8bit import hsv8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue [7:0], saturation [15:8], brightness [23:16]
);

  logic              en [NCells+2];
  logic              vld [NCells+1];
  cell_t             dat [NCells+1];
  logic [ChanW-1:0]  hue_nxt, sat_nxt;
  logic [3*ChanW-1:0] out_data_r;
  logic              out_valid_r;

  assign en[NCells+1] = !out_valid_r || out_tready;
  assign in_tready    = en[0];

  hsv8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[0]),
    .in_valid (in_tvalid),
    .red      (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .blue     (in_tdata[23:16]),
    .valid_r  (vld[0]),
    .data_r   (dat[0])
  );
  assign en[0] = !vld[0] || en[1];

  for (genvar k = 1; k <= NCells; k++) begin : g_cell
    hsv8_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en[k]),
      .in_valid (vld[k-1]),
      .in_data  (dat[k-1]),
      .valid_r  (vld[k]),
      .data_r   (dat[k])
    );
    assign en[k] = !vld[k] || en[k+1];
  end

  always_comb begin
    if (dat[NCells].side.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      sat_nxt = dat[NCells].sat.quo;
      if (dat[NCells].side.neg) begin
        hue_nxt = dat[NCells].side.offset - dat[NCells].hue.quo;
      end else begin
        hue_nxt = dat[NCells].side.offset + dat[NCells].hue.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[NCells+1]) begin
      out_valid_r <= vld[NCells];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NCells+1]) begin
      out_data_r <= {dat[NCells].side.bright, sat_nxt, hue_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
